// ===== sv/min_error_boundary_cut_assert.svh =====
// Assertion macros for the boundary cut block
`ifndef MIN_ERROR_BOUNDARY_CUT_ASSERT_SVH
`define MIN_ERROR_BOUNDARY_CUT_ASSERT_SVH
`ifndef SYNTHESIS
`define MEBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MEBC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MEBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MEBC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== sv/mebc_pkg.sv =====
// Shared constants and types for the boundary cut block
package mebc_pkg;
  localparam int TileMax    = 64;
  localparam int OverlapMax = 16;
  localparam int CostW      = 20;
  localparam int RadW       = 26;
  localparam int RootW      = 13;
  localparam int AcrW       = 4;
  localparam int StepW      = 6;
  localparam int DirAw      = StepW + AcrW;
  localparam logic [CostW-1:0] CostSat = {CostW{1'b1}};

  localparam logic [1:0] RegCutLeft = 2'd0;
  localparam logic [1:0] RegTile    = 2'd1;
  localparam logic [1:0] RegOverlap = 2'd2;

  localparam logic [1:0] DirDown = 2'd0;
  localparam logic [1:0] DirSame = 2'd1;
  localparam logic [1:0] DirUp   = 2'd2;

  typedef struct packed {
    logic             start;
    logic [RadW-1:0]  radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;
endpackage

// ===== sv/mebc_if.sv =====
// Valid/ready channel interfaces for pixel input and cut output
interface mebc_pix_if;
  logic        valid;
  logic        ready;
  logic [10:0] patch_l;
  logic [11:0] patch_a;
  logic [11:0] patch_b;
  logic [10:0] quilt_l;
  logic [11:0] quilt_a;
  logic [11:0] quilt_b;
  logic        final_pixel;
  modport source (output valid, patch_l, patch_a, patch_b, quilt_l, quilt_a, quilt_b,
                  final_pixel, input ready);
  modport sink (input valid, patch_l, patch_a, patch_b, quilt_l, quilt_a, quilt_b,
                final_pixel, output ready);
endinterface

interface mebc_cut_if;
  logic       valid;
  logic       ready;
  logic [3:0] cut_index;
  logic       last_step;
  modport source (output valid, cut_index, last_step, input ready);
  modport sink (input valid, cut_index, last_step, output ready);
endinterface

// ===== sv/mebc_isqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle
module mebc_isqrt
  import mebc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);
  localparam int Steps = RadW / 2;
  localparam int CntW  = $clog2(Steps + 1);

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RootW+2:0] rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [RootW+2:0] trial;
  logic [RootW+2:0] shifted;

  always_comb begin
    rad_d = rad_q; rem_d = rem_q; root_d = root_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q[RootW:0], rad_q[RadW-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    if (req_i.start) begin
      rad_d = req_i.radicand; rem_d = '0; root_d = '0;
      cnt_d = CntW'(Steps); busy_d = 1'b1;
    end else if (busy_q) begin
      // one root digit: compare the shifted remainder with 4r+1
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d = shifted - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;
endmodule

// ===== sv/min_error_boundary_cut.sv =====
// Top level: pixel intake, cost DP, seam backtrack and cut output
//
//  channel | dir | handshake     | payload
//  pix_if  | in  | valid/ready   | patch/quilt Lab pixel, final_pixel
//  cut_if  | out | valid/ready   | cut_index, last_step
//  apb     | in  | psel/penable  | cut_left, tile_size, overlap_width
//
// Each pixel is squared channel by channel, its root is taken in the root
// unit (13 digit steps, then the root is handed back), and a DP update runs
// in StDp and StDpW; only back in idle does the block take the next transfer.
// The run's end adds a min search over the last step (one cell a cycle),
// a backtrack through the direction memory (StRead, StWait and StEmit for
// each step) and a StPush state to hand the path to the replay stage.
// Cut results are replayed upward from a stack, one a cycle while the sink
// takes them; the next run's pixels overlap the replay, and its trace holds
// until the replay has drained the stack.
// Reset clears all control state; the direction memory is never cleared.
module min_error_boundary_cut
  import mebc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mebc_pix_if.sink    pix_if,
  mebc_cut_if.source  cut_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
`include "min_error_boundary_cut_assert.svh"

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSq    = 4'd1;
  localparam logic [3:0] StRoot  = 4'd2;
  localparam logic [3:0] StWait  = 4'd3;
  localparam logic [3:0] StDp    = 4'd4;
  localparam logic [3:0] StMin   = 4'd5;
  localparam logic [3:0] StRead  = 4'd6;
  localparam logic [3:0] StEmit  = 4'd7;
  localparam logic [3:0] StPush  = 4'd8;
  localparam logic [3:0] StDpW   = 4'd9;

  // configuration
  logic       cut_left_q;
  logic [6:0] tile_q;
  logic [4:0] ow_q;
  logic       wr_en;
  logic       cfg_wr;
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  // only a write to a mapped register restarts the run
  assign cfg_wr = wr_en && (paddr[3:2] <= RegOverlap);

  always_comb begin
    unique case (paddr[3:2])
      RegCutLeft: prdata = {31'd0, cut_left_q};
      RegTile:    prdata = {25'd0, tile_q};
      RegOverlap: prdata = {27'd0, ow_q};
      default:    prdata = '0;
    endcase
  end

  logic [6:0] ts_eff;
  logic [4:0] ow_eff;
  assign ts_eff = (tile_q < 7'd2) ? 7'd2 : ((tile_q > 7'(TileMax)) ? 7'(TileMax) : tile_q);
  assign ow_eff = (ow_q < 5'd2) ? 5'd2 : ((ow_q > 5'(OverlapMax)) ? 5'(OverlapMax) : ow_q);

  logic [3:0]       st_q, st_d;
  logic [StepW-1:0] s_q, s_d;
  logic [AcrW-1:0]  j_q, j_d;
  logic [CostW-1:0] prior_q [OverlapMax];
  logic [CostW-1:0] cur_q   [OverlapMax];
  logic             fin_q;
  logic [12:0]      dl_q, da_q, db_q;
  logic [1:0]       sqc_q;
  logic [RadW-1:0]  acc_q;
  logic [11:0]      mag;
  logic [23:0]      sq;
  logic [RootW-1:0] cell_q;
  logic [StepW-1:0] k_q;
  logic [AcrW-1:0]  pos_q, mi_q;
  logic [CostW-1:0] best_q;
  logic [1:0]       dir_mem [TileMax*OverlapMax];
  logic [1:0]       dir_rd_q;
  logic [StepW-1:0] ls_q;

  // The trace runs from the last step down, so results are staged in a
  // stack and replayed upward.
  logic [3:0]       stk_q [TileMax];
  logic [StepW:0]   sp_q;
  logic             rp_v_q;
  logic [3:0]       rp_idx_q;
  logic             rp_last_q;
  logic [StepW:0]   rp_n_q;
  logic             rp_go;
  logic             rp_load;

  sqrt_req_t sreq;
  sqrt_rsp_t srsp;
  mebc_isqrt u_isqrt (.clk_i, .rst_ni, .req_i(sreq), .rsp_o(srsp));

  logic        accept;
  logic        s_wrap;
  logic [StepW-1:0] s_use;
  logic [AcrW-1:0]  j_use;
  assign pix_if.ready = (st_q == StIdle);
  assign accept = pix_if.valid && pix_if.ready;
  // restart from zero when counters sit beyond a shrunken region
  assign s_wrap = ({1'b0, s_q} >= ts_eff) || ({1'b0, j_q} >= ow_eff);
  assign s_use = s_wrap ? '0 : s_q;
  assign j_use = s_wrap ? '0 : j_q;

  // one squarer, shared over the three channel differences
  always_comb begin
    unique case (sqc_q)
      2'd0: mag = dl_q[12] ? 12'(-dl_q) : dl_q[11:0];
      2'd1: mag = da_q[12] ? 12'(-da_q) : da_q[11:0];
      default: mag = db_q[12] ? 12'(-db_q) : db_q[11:0];
    endcase
    sq = mag * mag;
  end
  assign sreq.start = (st_q == StSq) && (sqc_q == 2'd2);
  assign sreq.radicand = acc_q + RadW'(sq);

  // DP neighbour pick, ties to the lower index
  logic [CostW-1:0] nb_best, nb_sum;
  logic [1:0]       nb_dir;
  logic [CostW:0]   sum_w;
  logic             last_cell;
  always_comb begin
    nb_best = prior_q[j_q]; nb_dir = DirSame;
    if (j_q != '0 && prior_q[j_q - 1'b1] <= nb_best) begin
      nb_best = prior_q[j_q - 1'b1]; nb_dir = DirDown;
    end
    if ({1'b0, j_q} + 5'd1 < ow_eff && prior_q[j_q + 1'b1] < nb_best) begin
      nb_best = prior_q[j_q + 1'b1]; nb_dir = DirUp;
    end
    sum_w = (s_q == '0) ? {8'd0, cell_q} : ({1'b0, nb_best} + (CostW+1)'(cell_q));
    nb_sum = sum_w[CostW] ? CostSat : sum_w[CostW-1:0];
  end
  assign last_cell = fin_q || (({1'b0, s_q} == ts_eff - 7'd1) && ({1'b0, j_q} == ow_eff - 5'd1));

  // next position from a stored direction, clamped to the band
  logic [AcrW-1:0] pos_nx;
  always_comb begin
    pos_nx = pos_q;
    if (dir_rd_q == DirDown && pos_q != '0) pos_nx = pos_q - 1'b1;
    else if (dir_rd_q == DirUp && {1'b0, pos_q} + 5'd1 < ow_eff) pos_nx = pos_q + 1'b1;
  end

  always_comb begin
    st_d = st_q; s_d = s_q; j_d = j_q;
    unique case (st_q)
      StIdle:  if (accept) begin st_d = StSq; s_d = s_use; j_d = j_use; end
      StSq:    if (sqc_q == 2'd2) st_d = StRoot;
      StRoot:  if (srsp.done) st_d = StDp;
      StDp:    st_d = StDpW;
      StDpW:   begin
        if (last_cell) st_d = StMin;
        else begin
          st_d = StIdle;
          if ({1'b0, j_q} == ow_eff - 5'd1) begin s_d = s_q + 1'b1; j_d = '0; end
          else j_d = j_q + 1'b1;
        end
      end
      // hold the trace until the previous run's replay has left the stack
      StMin:   if (mi_q == j_q && rp_n_q == '0) st_d = StRead;
      StRead:  st_d = StWait;
      StWait:  st_d = StEmit;
      StEmit:  st_d = (k_q == '0) ? StPush : StRead;
      StPush:  begin
        st_d = StIdle; s_d = '0; j_d = '0;
      end
      default: st_d = StIdle;
    endcase
    if (cfg_wr) begin s_d = '0; j_d = '0; end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; s_q <= '0; j_q <= '0;
      cut_left_q <= 1'b1; tile_q <= 7'd32; ow_q <= 5'd8; sqc_q <= '0;
      for (int i = 0; i < OverlapMax; i++) begin
        prior_q[i] <= '0; cur_q[i] <= '0;
      end
    end else begin
      st_q <= st_d; s_q <= s_d; j_q <= j_d;
      if (wr_en) begin
        unique case (paddr[3:2])
          RegCutLeft: cut_left_q <= pwdata[0];
          RegTile:    tile_q <= pwdata[6:0];
          RegOverlap: ow_q <= pwdata[4:0];
          default: ;
        endcase
      end
      sqc_q <= (st_q == StSq) ? ((sqc_q == 2'd2) ? 2'd0 : sqc_q + 2'd1) : 2'd0;
      if (st_q == StDpW) begin
        cur_q[j_q] <= nb_sum;
        if (!last_cell && {1'b0, j_q} == ow_eff - 5'd1) begin
          for (int i = 0; i < OverlapMax; i++) prior_q[i] <= cur_q[i];
          prior_q[j_q] <= nb_sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dl_q <= {2'b00, pix_if.patch_l} - {2'b00, pix_if.quilt_l};
      da_q <= {pix_if.patch_a[11], pix_if.patch_a} - {pix_if.quilt_a[11], pix_if.quilt_a};
      db_q <= {pix_if.patch_b[11], pix_if.patch_b} - {pix_if.quilt_b[11], pix_if.quilt_b};
      fin_q <= pix_if.final_pixel;
      acc_q <= '0;
    end else if (st_q == StSq) acc_q <= acc_q + RadW'(sq);
    if (srsp.done) cell_q <= srsp.root;
    if (st_q == StDp && s_q != '0) dir_mem[{s_q, j_q}] <= nb_dir;
    if (st_q == StDpW) begin
      mi_q <= '0; pos_q <= '0; best_q <= (j_q == '0) ? nb_sum : cur_q[0];
      k_q <= s_q; ls_q <= s_q;
    end
    if (st_q == StMin && mi_q != j_q) begin
      mi_q <= mi_q + 1'b1;
      // candidate at mi+1; the newest cell already sits in cur_q
      if (cur_q[mi_q + 1'b1] < best_q) begin
        best_q <= cur_q[mi_q + 1'b1]; pos_q <= mi_q + 1'b1;
      end
    end
    if (st_q == StRead) dir_rd_q <= dir_mem[{k_q, pos_q}];
    // step the trace down one step
    if (st_q == StEmit && k_q != '0) begin
      pos_q <= pos_nx; k_q <= k_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StEmit) stk_q[k_q] <= pos_q;
  end

  assign rp_go = (st_q == StPush);
  assign rp_load = (rp_n_q != '0) && (!rp_v_q || cut_if.ready);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_v_q <= 1'b0; sp_q <= '0; rp_n_q <= '0;
    end else begin
      if (rp_go) begin
        sp_q <= '0; rp_n_q <= {1'b0, ls_q} + 1'b1;
      end else if (rp_load) begin
        rp_n_q <= rp_n_q - 1'b1; sp_q <= sp_q + 1'b1;
      end
      // hold the output register while the sink stalls
      if (rp_load) rp_v_q <= 1'b1;
      else if (cut_if.ready) rp_v_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (rp_load) begin
      rp_idx_q <= stk_q[sp_q[StepW-1:0]];
      rp_last_q <= (rp_n_q == (StepW+1)'(1));
    end
  end

  assign cut_if.valid     = rp_v_q;
  assign cut_if.cut_index = rp_idx_q;
  assign cut_if.last_step = rp_last_q;

  logic cut_stall;
  assign cut_stall = cut_if.valid && !cut_if.ready;

  `MEBC_ASSERT_NEXT(a_acc_busy, clk_i, rst_ni, accept, !pix_if.ready, "accepted while busy")
  `MEBC_ASSERT_NEXT(a_hold, clk_i, rst_ni, cut_stall, cut_if.valid, "dropped result")
  `MEBC_ASSERT_NEXT(a_stable, clk_i, rst_ni, cut_stall, $stable(rp_idx_q), "result moved")
  `MEBC_ASSERT(a_trace_free, clk_i, rst_ni, st_q != StRead || rp_n_q == '0, "trace in replay")
endmodule

// ===== bench/mebc_checker.sv =====
`timescale 1ns / 1ps
// Seam predictor and scoreboard for the boundary cut block
module mebc_checker
  import mebc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mebc_pix_if         pix_if,
  mebc_cut_if         cut_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          n_fail_o,
  output int          n_pending_o
);

  typedef struct packed {
    logic [3:0] cut_index;
    logic       last_step;
  } cut_t;

  logic             cfg_cut_left;
  logic [6:0]       cfg_tile;
  logic [4:0]       cfg_overlap;
  logic [CostW-1:0] prev_cost [OverlapMax];
  logic [CostW-1:0] curr_cost [OverlapMax];
  logic [1:0]       dir_mem   [TileMax*OverlapMax];
  int unsigned      step_q;
  int unsigned      acr_q;
  cut_t             cut_queue[$];
  int               n_fail;

  assign n_fail_o    = n_fail;
  assign n_pending_o = cut_queue.size();

  function automatic int unsigned root_floor(int unsigned v);
    int unsigned res;
    int unsigned b;
    res = 0;
    b = 32'h4000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned sq(int d);
    int unsigned a;
    a = (d < 0) ? -d : d;
    return a * a;
  endfunction

  // Advance the seam DP by one pixel; queue the cut path when the run ends.
  function automatic void seam_step(logic [10:0] pl, logic signed [11:0] pa,
                                    logic signed [11:0] pb, logic [10:0] ql,
                                    logic signed [11:0] qa, logic signed [11:0] qb,
                                    logic fin_bit);
    int unsigned ts, ow, s, j, cell_cost, best, cost, pos, k;
    logic [1:0]  dir;
    cut_t        r;
    ts = (cfg_tile < 2) ? 2 : (cfg_tile > TileMax) ? TileMax : cfg_tile;
    ow = (cfg_overlap < 2) ? 2 : (cfg_overlap > OverlapMax) ? OverlapMax : cfg_overlap;
    s = step_q;
    j = acr_q;
    if (s >= ts || j >= ow) begin
      s = 0;
      j = 0;
    end
    cell_cost = root_floor(sq(int'(pl) - int'(ql)) + sq(int'(pa) - int'(qa))
                           + sq(int'(pb) - int'(qb)));
    if (s == 0) begin
      cost = cell_cost;
    end else begin
      best = prev_cost[j];
      dir = DirSame;
      if (j > 0 && prev_cost[j-1] <= best) begin
        best = prev_cost[j-1];
        dir = DirDown;
      end
      if (j + 1 < ow && prev_cost[j+1] < best) begin
        best = prev_cost[j+1];
        dir = DirUp;
      end
      dir_mem[s*OverlapMax + j] = dir;
      cost = best + cell_cost;
      if (cost > CostSat) cost = CostSat;
    end
    curr_cost[j] = CostW'(cost);

    if (fin_bit || (s == ts - 1 && j == ow - 1)) begin
      cut_t path [TileMax];
      pos = 0;
      for (k = 1; k <= j; k++)
        if (curr_cost[k] < curr_cost[pos]) pos = k;
      // trace back from the last step, then emit from step 0 upward
      for (int i = s; i >= 0; i--) begin
        path[i].cut_index = pos[3:0];
        path[i].last_step = (i == s);
        if (i > 0) begin
          dir = dir_mem[i*OverlapMax + pos];
          if (dir == DirDown && pos > 0) pos--;
          else if (dir == DirUp && pos + 1 < ow) pos++;
        end
      end
      for (int i = 0; i <= s; i++) cut_queue = {cut_queue, path[i]};
      step_q = 0;
      acr_q = 0;
    end else if (j == ow - 1) begin
      prev_cost = curr_cost;
      step_q = s + 1;
      acr_q = 0;
    end else begin
      step_q = s;
      acr_q = j + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cut_t exp_cut;
    if (!rst_ni) begin
      cfg_cut_left = 1'b1;
      cfg_tile     = 7'd32;
      cfg_overlap  = 5'd8;
      step_q       = 0;
      acr_q        = 0;
      for (int i = 0; i < OverlapMax; i++) begin
        prev_cost[i] = '0;
        curr_cost[i] = '0;
      end
      cut_queue.delete();
      n_fail = 0;
    end else begin
      // compare first: a result never stems from the pixel of the same edge
      if (cut_if.valid && cut_if.ready) begin
        if (cut_queue.size() == 0) begin
          $error("unexpected cut transfer: cut_index %0d last_step %0d",
                 cut_if.cut_index, cut_if.last_step);
          n_fail++;
        end else begin
          exp_cut = cut_queue.pop_front();
          if (cut_if.cut_index !== exp_cut.cut_index) begin
            $error("cut_index: expected %0d, actual %0d", exp_cut.cut_index,
                   cut_if.cut_index);
            n_fail++;
          end
          if (cut_if.last_step !== exp_cut.last_step) begin
            $error("last_step: expected %0d, actual %0d", exp_cut.last_step,
                   cut_if.last_step);
            n_fail++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegCutLeft: cfg_cut_left = pwdata[0];
          RegTile:    cfg_tile     = pwdata[6:0];
          RegOverlap: cfg_overlap  = pwdata[4:0];
          default: ;
        endcase
        if (paddr[3:2] <= RegOverlap) begin
          step_q = 0;
          acr_q = 0;
        end
      end
      if (pix_if.valid && pix_if.ready)
        seam_step(pix_if.patch_l, pix_if.patch_a, pix_if.patch_b, pix_if.quilt_l,
                  pix_if.quilt_a, pix_if.quilt_b, pix_if.final_pixel);
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the boundary cut block
module tb_top;
  import mebc_pkg::*;

  typedef struct {
    logic [10:0] pl;
    logic [11:0] pa;
    logic [11:0] pb;
    logic [10:0] ql;
    logic [11:0] qa;
    logic [11:0] qb;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          n_fail;
  int          n_pending;
  int          n_sent = 0;
  int          send_idle_pct = 27;
  int          recv_idle_pct = 86;
  int unsigned eff_tile = 32;
  int unsigned eff_overlap = 8;

  mebc_pix_if pix_if ();
  mebc_cut_if cut_if ();

  min_error_boundary_cut i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_if  (pix_if),
    .cut_if  (cut_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mebc_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_if      (pix_if),
    .cut_if      (cut_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .n_fail_o    (n_fail),
    .n_pending_o (n_pending)
  );

  always #1 clk_i = ~clk_i;

  // Hold every input known from time zero.
  initial begin
    pix_if.valid       = 1'b0;
    pix_if.patch_l     = '0;
    pix_if.patch_a     = '0;
    pix_if.patch_b     = '0;
    pix_if.quilt_l     = '0;
    pix_if.quilt_a     = '0;
    pix_if.quilt_b     = '0;
    pix_if.final_pixel = 1'b0;
    cut_if.ready       = 1'b0;
  end

  // Receiver back-pressure: stall at the rate of the current idling phase.
  always @(posedge clk_i) begin
    cut_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Idling schedule: sender light/receiver heavy, then swapped, then none.
  always @(posedge clk_i) begin
    if (n_sent < 120) begin
      send_idle_pct <= 27;
      recv_idle_pct <= 86;
    end else if (n_sent < 240) begin
      send_idle_pct <= 86;
      recv_idle_pct <= 27;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  // One APB write: setup cycle, then access cycle until the transfer.
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain all expected cuts, then let any result-free pixel work finish.
  task automatic settle();
    wait (n_pending == 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_geometry(logic cut_left, int unsigned tile, int unsigned overlap);
    settle();
    reg_write(RegCutLeft, {31'd0, cut_left});
    reg_write(RegTile, tile);
    reg_write(RegOverlap, overlap);
    eff_tile    = (tile[6:0] < 2) ? 2 : (tile[6:0] > TileMax) ? TileMax : tile[6:0];
    eff_overlap = (overlap[4:0] < 2) ? 2
                : (overlap[4:0] > OverlapMax) ? OverlapMax : overlap[4:0];
  endtask

  // Present one pixel; the valid stays high into the next pixel unless idling.
  task automatic send_pixel(pixel_t p, logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      repeat (1 + $urandom_range(3)) @(posedge clk_i);
    end
    if (!pix_if.valid) @(posedge clk_i);
    pix_if.valid       <= 1'b1;
    pix_if.patch_l     <= p.pl;
    pix_if.patch_a     <= p.pa;
    pix_if.patch_b     <= p.pb;
    pix_if.quilt_l     <= p.ql;
    pix_if.quilt_a     <= p.qa;
    pix_if.quilt_b     <= p.qb;
    pix_if.final_pixel <= fin;
    do @(posedge clk_i); while (!pix_if.ready);
    n_sent++;
  endtask

  task automatic pix_idle();
    @(posedge clk_i);
    pix_if.valid <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int m;
    m = $urandom_range(9);
    p.pl = (m == 0) ? 11'($urandom) : 11'($urandom_range(1600));
    p.pa = 12'($urandom);
    p.pb = 12'($urandom);
    if (m < 3) begin
      // unrelated pixels, a and b over the full field range
      p.ql = (m == 0) ? 11'($urandom) : 11'($urandom_range(1600));
      p.qa = 12'($urandom);
      p.qb = 12'($urandom);
    end else if (m < 5) begin
      // identical pixels: zero cost, forces ties
      p.ql = p.pl;
      p.qa = p.pa;
      p.qb = p.pb;
    end else begin
      // near match: small costs, many close paths
      p.ql = p.pl + 11'($urandom_range(6));
      p.qa = p.pa - 12'($urandom_range(6));
      p.qb = p.pb + 12'($urandom_range(6));
    end
    return p;
  endfunction

  // One run of random pixels, ending early now and then.
  task automatic random_run();
    int unsigned n;
    int unsigned stop_at;
    bit          early;
    n = eff_tile * eff_overlap;
    early = ($urandom_range(3) == 0);
    stop_at = early ? $urandom_range(n - 1) : n - 1;
    for (int unsigned k = 0; k <= stop_at; k++)
      send_pixel(rand_pixel(), (k == stop_at) && (early || $urandom_range(1)));
  endtask

  initial begin
    pixel_t p;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: smallest band, extremes of every field.
    set_geometry(1'b0, 2, 2);
    p = '{pl: 11'd7, pa: 12'd3, pb: -12'sd3, ql: 11'd7, qa: 12'd3, qb: -12'sd3};
    repeat (4) send_pixel(p, 1'b0);        // all ties: lowest index wins
    p = '{pl: 11'd2047, pa: 12'h800, pb: 12'h800, ql: 11'd0, qa: 12'h7FF, qb: 12'h7FF};
    send_pixel(p, 1'b0);                   // largest distance
    p = '{pl: 11'd0, pa: 12'h7FF, pb: 12'h800, ql: 11'd1600, qa: 12'h800, qb: 12'h7FF};
    send_pixel(p, 1'b0);
    p = '{pl: 11'd1600, pa: 12'd0, pb: 12'd0, ql: 11'd1600, qa: 12'd0, qb: 12'd0};
    send_pixel(p, 1'b0);
    send_pixel(p, 1'b1);                   // final flag on the natural last pixel
    send_pixel(p, 1'b1);                   // early end on the very first pixel
    send_pixel(rand_pixel(), 1'b0);
    send_pixel(rand_pixel(), 1'b0);
    send_pixel(rand_pixel(), 1'b1);        // early end part way into step 1
    pix_idle();
    settle();
    // Out-of-range registers clamp; also restart a run left half done.
    send_pixel(rand_pixel(), 1'b0);
    pix_idle();
    set_geometry(1'b1, 0, 1);
    repeat (2) random_run();
    pix_idle();
    set_geometry(1'b1, 1, 0);
    random_run();
    pix_idle();

    // Random phases through several geometries.
    set_geometry(1'b1, 4, 16);
    while (n_sent < 90) random_run();
    pix_idle();
    set_geometry(1'b0, 9, 5);
    while (n_sent < 150) random_run();
    pix_idle();
    set_geometry(1'b1, 3, 3);
    while (n_sent < 190) random_run();
    pix_idle();
    set_geometry(1'b0, 127, 31);           // clamps to the largest band
    for (int k = 0; k < 20; k++) send_pixel(rand_pixel(), k == 19);
    pix_idle();
    set_geometry(1'b1, 64, 2);             // longest seam: most results a run
    for (int k = 0; k < 64 * 2; k++) send_pixel(rand_pixel(), 1'b0);
    pix_idle();
    set_geometry(1'b1, 32, 8);
    for (int k = 0; k < 10; k++) send_pixel(rand_pixel(), k == 9);
    pix_idle();

    settle();
    if (n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/mebc_pkg.sv
sv/mebc_if.sv
sv/mebc_isqrt.sv
sv/min_error_boundary_cut.sv
bench/mebc_checker.sv
bench/tb_top.sv
